>>> hw/rtl/bep_pkg.sv
`default_nettype none
// Shared constants and the per-frame summary type of the beacon element parser.
// Used by the front end, the summary queue, the result stage and the top level.
package bep_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int SsidMaxBytesDefault  = 32;
  localparam int MaxFrameBytesDefault = 4096;

  // Field widths fixed by the interface
  localparam int LenW   = 12;
  localparam int BssidW = 48;

  // Header (24) plus fixed beacon fields (12) come before the first element
  localparam int FixedPartBytes = 24 + 12;
  // Address 3 occupies bytes 16..21
  localparam int BssidFirstByte = 16;
  localparam int BssidBytes     = 6;

  // Results are four chunks of eight SSID bytes
  localparam int ChunkBytes    = 8;
  localparam int NumChunks     = 4;
  localparam int SsidPadBytes  = ChunkBytes * NumChunks;

  // Element tags of interest
  localparam logic [7:0] TAG_SSID = 8'd0;
  localparam logic [7:0] TAG_DS   = 8'd3;
  localparam logic [7:0] TAG_RSN  = 8'd48;

  // Element walk phases
  localparam logic [1:0] PH_TAG  = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  // What the front end hands over at the end of a frame
  typedef struct packed {
    logic                              accepted;
    logic [BssidW-1:0]                 bssid;
    logic [5:0]                        ssid_length;
    logic [7:0]                        channel;
    logic                              has_security;
    logic [SsidPadBytes-1:0][7:0]      ssid;
  } summary_t;

endpackage
`default_nettype wire

>>> hw/rtl/bep_front.sv
`default_nettype none
// Front end: takes one frame byte per beat, walks the elements and builds the
// frame summary. Depends on bep_pkg.
module bep_front #(
  parameter int SSID_MAX_BYTES  = bep_pkg::SsidMaxBytesDefault,
  parameter int MAX_FRAME_BYTES = bep_pkg::MaxFrameBytesDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [7:0]               data_byte_i,
  input  wire logic [bep_pkg::LenW-1:0] frame_length_i,
  input  wire logic                     last_byte_i,
  input  wire logic                     full_i,
  output logic                          push_o,
  output bep_pkg::summary_t             summary_o
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES);
  localparam int CMP_W = ((POS_W > bep_pkg::LenW) ? POS_W : bep_pkg::LenW) + 2;

  logic [POS_W-1:0]          pos_q, pos_d;
  logic [bep_pkg::LenW-1:0]  len_q, len_d;
  logic [1:0]                phase_q, phase_d;
  logic [7:0]                tag_q, tag_d;
  logic [7:0]                rem_q, rem_d;
  logic [7:0]                off_q, off_d;
  logic                      stop_q, stop_d;
  logic [SSID_MAX_BYTES-1:0][7:0] store_q, store_d;
  logic [5:0]                count_q, count_d;
  logic [7:0]                chan_q, chan_d;
  logic                      sec_q, sec_d;
  logic [bep_pkg::BssidW-1:0] bssid_q, bssid_d;

  logic             accept;
  logic             first;
  logic             active;
  logic [CMP_W-1:0] pos_x, len_x, byte_x;
  logic [7:0]       ssid_pad [bep_pkg::SsidPadBytes];

  // Stall whenever the summary queue has no room
  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;
  assign push_o     = accept & last_byte_i;
  assign first      = (pos_q == '0);

  assign pos_x  = CMP_W'(pos_q);
  assign len_x  = CMP_W'(first ? frame_length_i : len_q);
  assign byte_x = CMP_W'(data_byte_i);

  // Next state for the byte on the input
  always_comb begin
    // Latch the length and clear per-frame state on the first byte
    len_d   = first ? frame_length_i : len_q;
    phase_d = first ? bep_pkg::PH_TAG : phase_q;
    tag_d   = first ? '0 : tag_q;
    rem_d   = first ? '0 : rem_q;
    off_d   = first ? '0 : off_q;
    stop_d  = first ? 1'b0 : stop_q;
    store_d = first ? '0 : store_q;
    count_d = first ? '0 : count_q;
    chan_d  = first ? '0 : chan_q;
    sec_d   = first ? 1'b0 : sec_q;
    bssid_d = first ? '0 : bssid_q;

    // Capture address 3
    for (int k = 0; k < bep_pkg::BssidBytes; k++) begin
      if (pos_q == POS_W'(bep_pkg::BssidFirstByte + k)) begin
        bssid_d[k*8 +: 8] = bssid_d[k*8 +: 8] | data_byte_i;
      end
    end

    // Element walk, only inside the frame and after the fixed part
    active = !stop_d && (pos_x >= CMP_W'(bep_pkg::FixedPartBytes)) && (pos_x < len_x);
    if (active) begin
      case (phase_d)
        bep_pkg::PH_TAG: begin
          if (pos_x + CMP_W'(2) > len_x) begin
            stop_d = 1'b1;
          end else begin
            tag_d   = data_byte_i;
            phase_d = bep_pkg::PH_LEN;
          end
        end
        bep_pkg::PH_LEN: begin
          if (pos_x + CMP_W'(1) + byte_x > len_x) begin
            stop_d = 1'b1;
          end else begin
            if (tag_d == bep_pkg::TAG_SSID) begin
              count_d = (data_byte_i > 8'(SSID_MAX_BYTES)) ? 6'(SSID_MAX_BYTES)
                                                          : data_byte_i[5:0];
              store_d = '0;
            end else if (tag_d == bep_pkg::TAG_RSN) begin
              sec_d = 1'b1;
            end
            rem_d   = data_byte_i;
            off_d   = '0;
            phase_d = (data_byte_i == '0) ? bep_pkg::PH_TAG : bep_pkg::PH_DATA;
          end
        end
        default: begin
          // Element body
          if (tag_d == bep_pkg::TAG_SSID && off_d < 8'(SSID_MAX_BYTES)) begin
            for (int i = 0; i < SSID_MAX_BYTES; i++) begin
              if (off_d == 8'(i)) begin
                store_d[i] = data_byte_i;
              end
            end
          end else if (tag_d == bep_pkg::TAG_DS && off_d == '0) begin
            chan_d = data_byte_i;
          end
          if (off_d != 8'hFF) begin
            off_d = off_d + 8'd1;
          end
          if (rem_d != '0) begin
            rem_d = rem_d - 8'd1;
          end
          if (rem_d == '0) begin
            phase_d = bep_pkg::PH_TAG;
          end
        end
      endcase
    end

    // Advance the position, saturating; restart after the last byte
    if (last_byte_i) begin
      pos_d = '0;
    end else if (pos_q < POS_W'(MAX_FRAME_BYTES - 1)) begin
      pos_d = pos_q + POS_W'(1);
    end else begin
      pos_d = pos_q;
    end
  end

  // Pad the SSID store out to the full result width
  for (genvar j = 0; j < bep_pkg::SsidPadBytes; j++) begin : g_pad
    if (j < SSID_MAX_BYTES) begin : g_byte
      assign ssid_pad[j] = store_d[j];
    end else begin : g_zero
      assign ssid_pad[j] = '0;
    end
  end

  // Build the summary from the state after this byte
  always_comb begin
    summary_o.accepted     = (len_d >= bep_pkg::LenW'(bep_pkg::FixedPartBytes));
    summary_o.bssid        = bssid_d;
    summary_o.ssid_length  = count_d;
    summary_o.channel      = chan_d;
    summary_o.has_security = sec_d;
    for (int j = 0; j < bep_pkg::SsidPadBytes; j++) begin
      summary_o.ssid[j] = ssid_pad[j];
    end
  end

  // Hold state between beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      len_q   <= '0;
      phase_q <= bep_pkg::PH_TAG;
      tag_q   <= '0;
      rem_q   <= '0;
      off_q   <= '0;
      stop_q  <= 1'b0;
      store_q <= '0;
      count_q <= '0;
      chan_q  <= '0;
      sec_q   <= 1'b0;
      bssid_q <= '0;
    end else if (accept) begin
      pos_q   <= pos_d;
      len_q   <= len_d;
      phase_q <= phase_d;
      tag_q   <= tag_d;
      rem_q   <= rem_d;
      off_q   <= off_d;
      stop_q  <= stop_d;
      store_q <= store_d;
      count_q <= count_d;
      chan_q  <= chan_d;
      sec_q   <= sec_d;
      bssid_q <= bssid_d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/bep_fifo.sv
`default_nettype none
// Two-entry queue of frame summaries between the front end and the result
// stage. Depends on bep_pkg.
module bep_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire bep_pkg::summary_t  wdata_i,
  input  wire logic               pop_i,
  output bep_pkg::summary_t       rdata_o,
  output logic                    full_o,
  output logic                    empty_o
);

  localparam int DEPTH = 2;

  bep_pkg::summary_t mem_q [DEPTH];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == 2'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the summary; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/bep_back.sv
`default_nettype none
// Result stage: emits four result beats per frame summary, one SSID chunk
// each, from the head of the summary queue. Depends on bep_pkg.
module bep_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bep_pkg::summary_t           head_i,
  input  wire logic                        empty_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             accepted_o,
  output logic [bep_pkg::BssidW-1:0]       bssid_o,
  output logic [5:0]                       ssid_length_o,
  output logic [7:0]                       channel_o,
  output logic                             has_security_o,
  output logic [1:0]                       chunk_index_o,
  output logic [63:0]                      ssid_chunk_o,
  output logic                             last_result_o
);

  logic [1:0]                           chunk_q, chunk_d;
  logic                                 out_take;
  logic [bep_pkg::ChunkBytes-1:0][7:0]  chunk_raw;
  logic [bep_pkg::ChunkBytes-1:0][7:0]  chunk_masked;
  logic                                 acc;

  assign out_valid_o = ~empty_i;
  assign out_take    = out_valid_o & ~out_stall_i;
  assign last_result_o = (chunk_q == 2'(bep_pkg::NumChunks - 1));
  assign pop_o       = out_take & last_result_o;
  assign chunk_index_o = chunk_q;

  // Select the chunk and zero the bytes beyond the SSID length
  always_comb begin
    for (int i = 0; i < bep_pkg::ChunkBytes; i++) begin
      chunk_raw[i]    = head_i.ssid[{chunk_q, 3'(i)}];
      chunk_masked[i] = ({1'b0, chunk_q, 3'(i)} < head_i.ssid_length) ? chunk_raw[i] : '0;
    end
  end

  // Zero every frame field of a short frame
  assign acc            = head_i.accepted;
  assign accepted_o     = acc;
  assign bssid_o        = acc ? head_i.bssid : '0;
  assign ssid_length_o  = acc ? head_i.ssid_length : '0;
  assign channel_o      = acc ? head_i.channel : '0;
  assign has_security_o = acc & head_i.has_security;
  assign ssid_chunk_o   = acc ? chunk_masked : '0;

  // Step through the chunks, wrap after the fourth
  always_comb begin
    chunk_d = chunk_q;
    if (out_take) begin
      chunk_d = last_result_o ? '0 : chunk_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= '0;
    end else begin
      chunk_q <= chunk_d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/beacon_element_parser_core.sv
`default_nettype none
// Beacon and probe-response information element parser, top level.
// Depends on bep_pkg, bep_front, bep_fifo and bep_back.
//
// Frame bytes enter at one beat per cycle unless the input stalls; the front
// end updates the element walk as each byte is taken. On a frame's last byte a
// summary (BSSID, SSID, channel, security flag) goes into a two-entry queue;
// the result stage sends it out as four beats, one 8-byte SSID chunk per cycle
// unless the output stalls. The input stalls only while the queue is full, so
// with no output stall frames of four bytes or more run at one byte per cycle;
// shorter ones are bound by the four result beats. No start-up clearing pass.
module beacon_element_parser_core #(
  parameter int SSID_MAX_BYTES  = bep_pkg::SsidMaxBytesDefault,
  parameter int MAX_FRAME_BYTES = bep_pkg::MaxFrameBytesDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [7:0]                 data_byte_i,
  input  wire logic [bep_pkg::LenW-1:0]   frame_length_i,
  input  wire logic                       last_byte_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            accepted_o,
  output logic [bep_pkg::BssidW-1:0]      bssid_o,
  output logic [5:0]                      ssid_length_o,
  output logic [7:0]                      channel_o,
  output logic                            has_security_o,
  output logic [1:0]                      chunk_index_o,
  output logic [63:0]                     ssid_chunk_o,
  output logic                            last_result_o
);

  bep_pkg::summary_t push_data;
  bep_pkg::summary_t head;
  logic              push, pop, full, empty;

  bep_front #(
    .SSID_MAX_BYTES (SSID_MAX_BYTES),
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .frame_length_i(frame_length_i),
    .last_byte_i   (last_byte_i),
    .full_i        (full),
    .push_o        (push),
    .summary_o     (push_data)
  );

  bep_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(push_data),
    .pop_i  (pop),
    .rdata_o(head),
    .full_o (full),
    .empty_o(empty)
  );

  bep_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .accepted_o    (accepted_o),
    .bssid_o       (bssid_o),
    .ssid_length_o (ssid_length_o),
    .channel_o     (channel_o),
    .has_security_o(has_security_o),
    .chunk_index_o (chunk_index_o),
    .ssid_chunk_o  (ssid_chunk_o),
    .last_result_o (last_result_o)
  );

endmodule
`default_nettype wire

>>> hw/rtl/bep_checker.sv
`default_nettype none
// Port-level checks for the beacon element parser, bound to the top level.
// Depends on bep_pkg.
module bep_checker (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     out_valid_o,
  input wire logic                     out_stall_i,
  input wire logic                     accepted_o,
  input wire logic [bep_pkg::BssidW-1:0] bssid_o,
  input wire logic [5:0]               ssid_length_o,
  input wire logic [7:0]               channel_o,
  input wire logic                     has_security_o,
  input wire logic [1:0]               chunk_index_o,
  input wire logic [63:0]              ssid_chunk_o,
  input wire logic                     last_result_o
);

  // Hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(chunk_index_o)
      && $stable(ssid_chunk_o) && $stable(bssid_o))
    else $error("stalled result beat changed");

  // Chunks of one frame follow in order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_result_o |=>
      out_valid_o && chunk_index_o == $past(chunk_index_o) + 2'd1)
    else $error("chunk sequence broken");

  // The final beat is the fourth chunk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_result_o == (chunk_index_o == 2'd3)))
    else $error("last_result does not match chunk index");

  // A short frame reports only zeros
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> bssid_o == '0 && ssid_length_o == '0
      && channel_o == '0 && !has_security_o && ssid_chunk_o == '0)
    else $error("short frame carries data");

  // SSID length stays within the SSID element limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ssid_length_o <= 6'd32)
    else $error("SSID length out of range");

endmodule

bind beacon_element_parser_core bep_checker u_bep_checker (.*);
`default_nettype wire
